/* rtl/core/cdq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
//
// Holds the store depth, the index and capacity widths, the operation and
// status codes, the transfer structs and the controller command group.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Store geometry.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // Operation codes; the unused codes behave as a query.
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_QUERY      = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  // One operation request.
  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // One result.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/cdq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl: operation sequencer
//
// Steps each accepted operation through capture, update, read and present,
// and drives busy and the result strobe.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output cdq_pkg::ctrl_t     ctrl,
  output logic               busy,
  output logic               done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  state_t state;

  // State register with registered busy and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_RESP;
          done  <= 1'b1;
        end
        S_RESP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Datapath commands follow the current step.
  always_comb begin
    ctrl.load = start && (state == S_IDLE);
    ctrl.exec = (state == S_EXEC);
    ctrl.read = (state == S_READ);
  end

endmodule
`default_nettype wire

/* rtl/core/cdq_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_dpath: deque datapath
//
// Holds the capacity register, the head and tail indices, the empty mark and
// the slot store, and forms the result from registered store reads.
// ----------------------------------------------------------------------------
module cdq_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cdq_pkg::ctrl_t             ctrl,
  input  wire cdq_pkg::cmd_t              cmd,
  input  wire logic                       cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]  cfg_wdata,
  output cdq_pkg::result_t                result
);

  logic [cdq_pkg::CAP_W-1:0]  capacity;
  logic [cdq_pkg::CAP_W-1:0]  cap_eff;
  logic [cdq_pkg::IDX_W-1:0]  head_index;
  logic [cdq_pkg::IDX_W-1:0]  tail_index;
  logic                       empty_mark;
  logic [cdq_pkg::IDX_W-1:0]  head_next;
  logic [cdq_pkg::IDX_W-1:0]  tail_next;
  logic                       empty_next;
  logic [2:0]                 mode;
  logic [cdq_pkg::DATA_W-1:0] value;
  logic [1:0]                 status;
  logic [1:0]                 status_next;
  logic                       wr_en;
  logic [cdq_pkg::IDX_W-1:0]  wr_addr;
  logic [cdq_pkg::DATA_W-1:0] slots [cdq_pkg::DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rd_front;
  logic [cdq_pkg::DATA_W-1:0] rd_rear;
  logic [cdq_pkg::IDX_W-1:0]  head_inc;
  logic [cdq_pkg::IDX_W-1:0]  head_dec;
  logic [cdq_pkg::IDX_W-1:0]  tail_inc;
  logic [cdq_pkg::IDX_W-1:0]  tail_dec;
  logic                       is_full_now;
  logic                       is_push;
  logic                       is_pop;

  // Wrapping increment modulo the effective capacity.
  function automatic logic [cdq_pkg::IDX_W-1:0] wrap_inc(
    input logic [cdq_pkg::IDX_W-1:0] idx,
    input logic [cdq_pkg::CAP_W-1:0] cap
  );
    logic [cdq_pkg::CAP_W-1:0] sum;
    sum = {1'b0, idx} + cdq_pkg::CAP_W'(1);
    return (sum >= cap) ? '0 : sum[cdq_pkg::IDX_W-1:0];
  endfunction

  // Wrapping decrement modulo the effective capacity.
  function automatic logic [cdq_pkg::IDX_W-1:0] wrap_dec(
    input logic [cdq_pkg::IDX_W-1:0] idx,
    input logic [cdq_pkg::CAP_W-1:0] cap
  );
    logic [cdq_pkg::CAP_W-1:0] lim;
    lim = cap - cdq_pkg::CAP_W'(1);
    return (idx == '0) ? lim[cdq_pkg::IDX_W-1:0] : idx - cdq_pkg::IDX_W'(1);
  endfunction

  // Capacity saturated into one to the store depth.
  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = cdq_pkg::CAP_W'(1);
    end else if (capacity > cdq_pkg::CAP_RESET) begin
      cap_eff = cdq_pkg::CAP_RESET;
    end else begin
      cap_eff = capacity;
    end
  end

  // Neighbor indices and the full test on the current state.
  always_comb begin
    head_inc    = wrap_inc(head_index, cap_eff);
    head_dec    = wrap_dec(head_index, cap_eff);
    tail_inc    = wrap_inc(tail_index, cap_eff);
    tail_dec    = wrap_dec(tail_index, cap_eff);
    is_full_now = !empty_mark && (tail_inc == head_index);
    is_push     = (mode == cdq_pkg::MODE_PUSH_FRONT) || (mode == cdq_pkg::MODE_PUSH_REAR);
    is_pop      = (mode == cdq_pkg::MODE_POP_FRONT) || (mode == cdq_pkg::MODE_POP_REAR);
  end

  // Operation decode: next indices, store write and status.
  always_comb begin
    head_next   = head_index;
    tail_next   = tail_index;
    empty_next  = empty_mark;
    status_next = cdq_pkg::ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = head_index;
    if (is_push) begin
      if (is_full_now) begin
        status_next = cdq_pkg::ST_FULL;
      end else begin
        wr_en = 1'b1;
        if (empty_mark) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          wr_addr    = '0;
        end else if (mode == cdq_pkg::MODE_PUSH_FRONT) begin
          head_next = head_dec;
          wr_addr   = head_dec;
        end else begin
          tail_next = tail_inc;
          wr_addr   = tail_inc;
        end
      end
    end else if (is_pop) begin
      if (empty_mark) begin
        status_next = cdq_pkg::ST_EMPTY;
      end else if (head_index == tail_index) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (mode == cdq_pkg::MODE_POP_FRONT) begin
        head_next = head_inc;
      end else begin
        tail_next = tail_dec;
      end
    end
  end

  // Control state: capacity, indices and empty mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= cdq_pkg::CAP_RESET;
      head_index <= '0;
      tail_index <= '0;
      empty_mark <= 1'b1;
    end else if (cfg_we) begin
      capacity   <= cfg_wdata;
      head_index <= '0;
      tail_index <= '0;
      empty_mark <= 1'b1;
    end else if (ctrl.exec) begin
      head_index <= head_next;
      tail_index <= tail_next;
      empty_mark <= empty_next;
    end
  end

  // Request capture and status hold.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mode  <= cmd.mode;
      value <= cmd.value;
    end
    if (ctrl.exec) begin
      status <= status_next;
    end
  end

  // Slot store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      slots[wr_addr] <= value;
    end
    if (ctrl.read) begin
      rd_front <= slots[head_index];
      rd_rear  <= slots[tail_index];
    end
  end

  // Result assembly; an empty deque shows zero values.
  always_comb begin
    result.status      = status;
    result.front_value = empty_mark ? '0 : rd_front;
    result.rear_value  = empty_mark ? '0 : rd_rear;
    result.is_empty    = empty_mark;
    result.is_full     = is_full_now;
  end

endmodule
`default_nettype wire

/* rtl/core/circular_deque_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_top: double-ended queue in a circular store
//
// Each operation (push front, push rear, pop front, pop rear or query) is
// captured at the accepting edge and then passes through the update, read
// and present steps: the update step updates the indices and writes the
// store, the read step registers the store reads and raises done, and the
// edge that ends the present step takes the result. The sequencer handles
// one operation at a time and takes no new start until busy has fallen at
// the edge that takes the result. The result is on the result port for
// exactly one cycle while done is high and cannot be held off, so the
// receiver must take it then. A capacity write must be made only while the
// block is idle; the block does not enforce this. The write also empties
// the deque.
// ----------------------------------------------------------------------------
module circular_deque_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire cdq_pkg::cmd_t              cmd,
  output logic                            busy,
  output logic                            done,
  output cdq_pkg::result_t                result,
  input  wire logic                       cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]  cfg_wdata
);

  cdq_pkg::ctrl_t ctrl;

  // Operation sequencer.
  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  // Indices, store and result datapath.
  cdq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

endmodule
`default_nettype wire

/* rtl/core/cdq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks of the circular deque
//
// Watches the top-level ports for sequencing and result consistency, and is
// bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic             done,
  input  wire cdq_pkg::result_t result
);

  // An accepted transfer raises busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transfer");

  // A result strobe lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A result only appears while an operation is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without an operation in progress");

  // An empty deque shows zero values and is never full.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |->
      (result.front_value == '0 && result.rear_value == '0 && !result.is_full))
    else $error("empty result carries values or a full flag");

  // A refused push leaves the deque full.
  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == cdq_pkg::ST_FULL) |->
      (result.is_full && !result.is_empty))
    else $error("refused push reported on a deque that is not full");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the circular deque
//
// Drives push, pop and query commands through the start/busy handshake and
// checks every result strobe, field by field, against a typed script result
// or an in-bench model. A short scripted sequence covers the corner cases.
// Random phases follow, each under a fresh capacity with its own push/pop
// mix, so the deque is driven through empty, full, refused and wrapping states.
// ----------------------------------------------------------------------------
module tb_top;
  import cdq_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 8;

  // Unused operation codes, which the block treats as a query.
  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;

  // One row of the scripted sequence: a capacity write or a command, with
  // the result typed in where it is obvious.
  typedef struct packed {
    logic              cfg;
    logic [CAP_W-1:0]  cap;
    logic [2:0]        mode;
    logic [DATA_W-1:0] value;
    logic              typed;
    logic [1:0]        st;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic              empty;
    logic              full;
  } script_row_t;

  localparam int SCRIPT_LEN = 27;
  // Fields: cfg, cap, mode, value, typed, status, front, rear, empty, full.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, 5'd0,  MODE_QUERY,      32'h0,        1'b1, ST_DONE,  32'h0, 32'h0, 1'b1, 1'b0},
    '{1'b0, 5'd0,  MODE_POP_FRONT,  32'h0,        1'b1, ST_EMPTY, 32'h0, 32'h0, 1'b1, 1'b0},
    '{1'b0, 5'd0,  MODE_POP_REAR,   32'h0,        1'b1, ST_EMPTY, 32'h0, 32'h0, 1'b1, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_REAR,  32'h7fffffff, 1'b1, ST_DONE,
      32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_FRONT, 32'h80000000, 1'b1, ST_DONE,
      32'h80000000, 32'h7fffffff, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_REAR,  32'hffffffff, 1'b1, ST_DONE,
      32'h80000000, 32'hffffffff, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_SPARE_A,    32'ha5a5a5a5, 1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_SPARE_B,    32'h5a5a5a5a, 1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_SPARE_C,    32'hffffffff, 1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_POP_FRONT,  32'h0,        1'b1, ST_DONE,
      32'h7fffffff, 32'hffffffff, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_POP_REAR,   32'h0,        1'b1, ST_DONE,
      32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_POP_REAR,   32'h0,        1'b1, ST_DONE,  32'h0, 32'h0, 1'b1, 1'b0},
    '{1'b1, 5'd1,  MODE_QUERY,      32'h0,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_FRONT, 32'h0,        1'b1, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b1},
    '{1'b0, 5'd0,  MODE_PUSH_REAR,  32'h1,        1'b1, ST_FULL,  32'h0, 32'h0, 1'b0, 1'b1},
    '{1'b0, 5'd0,  MODE_POP_FRONT,  32'h0,        1'b1, ST_DONE,  32'h0, 32'h0, 1'b1, 1'b0},
    '{1'b1, 5'd0,  MODE_QUERY,      32'h0,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_REAR,  32'h12345678, 1'b1, ST_DONE,
      32'h12345678, 32'h12345678, 1'b0, 1'b1},
    '{1'b0, 5'd0,  MODE_PUSH_FRONT, 32'h5,        1'b1, ST_FULL,
      32'h12345678, 32'h12345678, 1'b0, 1'b1},
    '{1'b1, 5'd2,  MODE_QUERY,      32'h0,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_FRONT, 32'h55555555, 1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_FRONT, 32'haaaaaaaa, 1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_REAR,  32'h3,        1'b1, ST_FULL,
      32'haaaaaaaa, 32'h55555555, 1'b0, 1'b1},
    '{1'b0, 5'd0,  MODE_POP_REAR,   32'h0,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 5'd31, MODE_QUERY,      32'h0,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_PUSH_REAR,  32'h1,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 5'd0,  MODE_QUERY,      32'h0,        1'b0, ST_DONE,  32'h0, 32'h0, 1'b0, 1'b0}
  };

  logic             clk;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  cmd_t             cmd       = '0;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             busy;
  logic             done;
  result_t          result;

  circular_deque_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Deque state as the bench tracks it.
  logic [DATA_W-1:0] dq_slots [DEPTH];
  int unsigned       dq_head;
  int unsigned       dq_tail;
  logic              dq_empty;
  logic [CAP_W-1:0]  dq_cap;

  result_t pending_results [$];
  int      items_accepted = 0;
  int      results_seen   = 0;
  int      fail_count     = 0;
  int      stall_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Capacity as the block uses it, saturated into 1..DEPTH.
  function automatic int unsigned usable_slots();
    if (dq_cap == 0) return 1;
    if (dq_cap > DEPTH) return DEPTH;
    return dq_cap;
  endfunction

  function automatic int unsigned step_up(int unsigned i, int unsigned n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned i, int unsigned n);
    return (i == 0) ? n - 1 : i - 1;
  endfunction

  function automatic logic deque_full(int unsigned n);
    return !dq_empty && step_up(dq_tail, n) == dq_head;
  endfunction

  // Applies one command to the tracked deque and returns its result.
  function automatic result_t apply_deque_op(cmd_t c);
    int unsigned n;
    result_t     r;
    n = usable_slots();
    r = '0;
    r.status = ST_DONE;
    case (c.mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (deque_full(n)) begin
          r.status = ST_FULL;
        end else begin
          if (dq_empty) begin
            dq_head  = 0;
            dq_tail  = 0;
            dq_empty = 1'b0;
          end else if (c.mode == MODE_PUSH_FRONT) begin
            dq_head = step_down(dq_head, n);
          end else begin
            dq_tail = step_up(dq_tail, n);
          end
          dq_slots[(c.mode == MODE_PUSH_FRONT) ? dq_head : dq_tail] = c.value;
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (dq_empty) begin
          r.status = ST_EMPTY;
        end else if (dq_head == dq_tail) begin
          // The last element leaves: both indices return to zero.
          dq_head  = 0;
          dq_tail  = 0;
          dq_empty = 1'b1;
        end else if (c.mode == MODE_POP_FRONT) begin
          dq_head = step_up(dq_head, n);
        end else begin
          dq_tail = step_down(dq_tail, n);
        end
      end
      default: ;
    endcase
    r.front_value = dq_empty ? '0 : dq_slots[dq_head];
    r.rear_value  = dq_empty ? '0 : dq_slots[dq_tail];
    r.is_empty    = dq_empty;
    r.is_full     = deque_full(n);
    return r;
  endfunction

  // Sends one command after a random gap and waits for the transfer.
  task automatic send_cmd(input cmd_t c, input logic typed, input result_t want);
    int      gap;
    result_t got_pred;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    got_pred = apply_deque_op(c);
    pending_results.push_back(typed ? want : got_pred);
    items_accepted++;
  endtask

  // Waits for the block to drain, then writes the capacity register.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (results_seen != items_accepted) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dq_cap   = cap;
    dq_head  = 0;
    dq_tail  = 0;
    dq_empty = 1'b1;
  endtask

  // Random element, with the extremes drawn more often than chance.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      2:       return 32'h7fffffff;
      3:       return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // Capacity for a random phase, leaning on the small and saturated ends.
  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd2;
      3:       return 5'd16;
      4:       return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_t want, input result_t got);
    check_field("status",      32'(want.status),   32'(got.status));
    check_field("front_value", want.front_value,   got.front_value);
    check_field("rear_value",  want.rear_value,    got.rear_value);
    check_field("is_empty",    32'(want.is_empty), 32'(got.is_empty));
    check_field("is_full",     32'(want.is_full),  32'(got.is_full));
  endtask

  // Each result strobe is compared against the oldest outstanding result.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
      end else begin
        check_result(pending_results.pop_front(), result);
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    script_row_t row;
    cmd_t        c;
    int          rand_sent;
    int          phase_len;
    int          push_pct;
    int          draw;
    foreach (dq_slots[i]) dq_slots[i] = '0;
    dq_cap    = CAP_RESET;
    dq_head   = 0;
    dq_tail   = 0;
    dq_empty  = 1'b1;
    rand_sent = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Scripted corner cases.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row = SCRIPT[i];
      if (row.cfg) begin
        write_capacity(row.cap);
      end else begin
        c.mode  = row.mode;
        c.value = row.value;
        send_cmd(c, row.typed, '{row.st, row.front, row.rear, row.empty, row.full});
      end
    end

    // Random phases, each under a new capacity and push/pop balance.
    while (rand_sent < RANDOM_ITEMS) begin
      write_capacity(pick_capacity());
      phase_len = $urandom_range(40, 120);
      push_pct  = $urandom_range(20, 80);
      for (int k = 0; k < phase_len && rand_sent < RANDOM_ITEMS; k++) begin
        draw = $urandom_range(0, 99);
        if (draw < 4)
          c.mode = 3'($urandom_range(MODE_QUERY, MODE_SPARE_C));
        else if (draw < push_pct)
          c.mode = 3'($urandom_range(MODE_PUSH_FRONT, MODE_PUSH_REAR));
        else
          c.mode = 3'($urandom_range(MODE_POP_FRONT, MODE_POP_REAR));
        c.value = pick_value();
        send_cmd(c, 1'b0, '0);
        rand_sent++;
      end
    end

    // Let the last results come out, then report.
    start <= 1'b0;
    while (results_seen != items_accepted) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
